[rtl/vdm_pkg.sv]
// Package: shared types, constants and arithmetic helpers for the drift monitor
package vdm_pkg;

  localparam int DIMENSIONS = 8;
  localparam int DIM_W      = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int Q16_SHIFT  = 16;
  localparam logic signed [31:0] Q16_ONE        = 32'sh0001_0000;
  localparam logic signed [31:0] DRIFT_LIMIT_RST = 32'sh0010_0000;

  // request kinds
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_FORCE  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         dim_index;
    logic signed [31:0] new_coord;
    logic signed [31:0] time_step;
  } vdm_in_t;

  typedef struct packed {
    logic               accepted;
    logic               stasis;
    logic               suspend_pulse;
    logic               locked;
    logic signed [31:0] divergence;
    logic signed [31:0] coord_norm;
    logic [31:0]        transition_count;
    logic [31:0]        clamp_count;
  } vdm_out_t;

  // divider handshake
  typedef struct packed {
    logic               start;
    logic signed [31:0] diff;
    logic signed [31:0] step;
  } vdm_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } vdm_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRD_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_VEL_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_CLR,
    ST_NORM_RD,
    ST_NORM_ACC,
    ST_OUT
  } vdm_state_t;

  // Q16 square of a 32-bit signed value, bits 47:16 of the 64-bit product
  function automatic logic [31:0] q16_sq(input logic signed [31:0] v);
    logic signed [63:0] p;
    p = 64'(v) * 64'(v);
    return p[47:16];
  endfunction

endpackage

[rtl/velocity_drift_monitor.sv]
// Top level: sequencer over the vector memories, divider and result register
// One request at a time. An update that is taken reads the old coordinate
// from memory, starts the divider, waits on the bit-serial divider (64
// quotient bits and then its done flag), writes the coordinate and velocity
// back, walks over the velocity squares and then over the coordinate
// squares, and loads the output register. The next request can be taken
// in the same cycle that the result becomes visible. An update that
// reaches the drift limit instead clears the velocities, one entry at a
// time, before the coordinate walk. A force request or an out-of-range
// dimension takes the clear plus the coordinate walk. An update in stasis
// only walks the coordinates. The output register is loaded only once the
// previous result no longer sits unaccepted in it.
module velocity_drift_monitor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vdm_pkg::vdm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vdm_pkg::vdm_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import vdm_pkg::*;

  vdm_state_t state_r, state_nxt;
  vdm_in_t    req_r, req_nxt;
  logic [DIM_W:0] idx_r, idx_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic signed [31:0] vel_r, vel_nxt;
  logic signed [31:0] limit_r;
  logic signed [31:0] div_r, div_nxt;
  logic [31:0] trans_r, trans_nxt, clamp_r, clamp_nxt;
  logic locked_r, locked_nxt, stasis_r, stasis_nxt;
  logic acc_r, acc_nxt, pulse_r, pulse_nxt;
  logic out_valid_r, out_valid_nxt;
  vdm_out_t out_r, out_nxt;

  logic [DIM_W-1:0] rd_addr, wr_addr;
  logic signed [31:0] crd_rdata, vel_rdata, crd_wdata, vel_wdata;
  logic crd_we, vel_we;
  vdm_div_req_t dreq;
  vdm_div_rsp_t drsp;
  logic in_fire, out_free;

  vdm_vec_mem u_mem (
    .clk, .rst_n, .rd_addr, .crd_rdata, .vel_rdata,
    .crd_we, .vel_we, .wr_addr, .crd_wdata, .vel_wdata
  );

  vdm_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    vel_nxt     = vel_r;
    div_nxt     = div_r;
    trans_nxt   = trans_r;
    clamp_nxt   = clamp_r;
    locked_nxt  = locked_r;
    stasis_nxt  = stasis_r;
    acc_nxt     = acc_r;
    pulse_nxt   = pulse_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_addr   = idx_r[DIM_W-1:0];
    wr_addr   = req_r.dim_index[DIM_W-1:0];
    crd_we    = 1'b0;
    vel_we    = 1'b0;
    crd_wdata = req_r.new_coord;
    vel_wdata = vel_r;
    dreq.start = 1'b0;
    dreq.diff  = req_r.new_coord - crd_rdata;
    dreq.step  = req_r.time_step;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt   = in_data;
          acc_nxt   = 1'b0;
          pulse_nxt = 1'b0;
          idx_nxt   = '0;
          if (in_data.req_type == REQ_FORCE) begin
            state_nxt = ST_CLR;
          end else if (stasis_r) begin
            state_nxt = ST_NORM_RD;
          end else if (in_data.dim_index >= 8'(DIMENSIONS)) begin
            state_nxt = ST_CLR;
          end else begin
            idx_nxt   = (DIM_W+1)'(in_data.dim_index);
            state_nxt = ST_CRD_RD;
          end
        end
      end
      ST_CRD_RD: state_nxt = ST_DIV_GO;
      ST_DIV_GO: begin
        // old coordinate is on the read port now
        dreq.start = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (drsp.done) begin
          vel_nxt   = drsp.quot;
          state_nxt = ST_VEL_WR;
        end
      end
      ST_VEL_WR: begin
        crd_we    = 1'b1;
        vel_we    = 1'b1;
        trans_nxt = trans_r + 32'd1;
        idx_nxt   = '0;
        sum_nxt   = '0;
        state_nxt = ST_SUM_RD;
      end
      ST_SUM_RD: begin
        rd_addr   = idx_r[DIM_W-1:0];
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        sum_nxt = sum_r + q16_sq(vel_rdata);
        if (idx_r == (DIM_W+1)'(DIMENSIONS)) begin
          div_nxt = signed'(sum_r + q16_sq(vel_rdata));
          if (signed'(sum_r + q16_sq(vel_rdata)) >= limit_r) begin
            idx_nxt   = '0;
            state_nxt = ST_CLR;
          end else begin
            locked_nxt = 1'b1;
            acc_nxt    = 1'b1;
            idx_nxt    = '0;
            state_nxt  = ST_NORM_RD;
          end
        end else begin
          rd_addr   = idx_r[DIM_W-1:0];
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_CLR: begin
        // zero one velocity entry a cycle
        wr_addr   = idx_r[DIM_W-1:0];
        vel_we    = 1'b1;
        vel_wdata = '0;
        if (idx_r == (DIM_W+1)'(DIMENSIONS - 1)) begin
          stasis_nxt = 1'b1;
          locked_nxt = 1'b0;
          clamp_nxt  = clamp_r + 32'd1;
          div_nxt    = '0;
          pulse_nxt  = 1'b1;
          acc_nxt    = 1'b0;
          idx_nxt    = '0;
          state_nxt  = ST_NORM_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_NORM_RD: begin
        sum_nxt   = '0;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_NORM_ACC;
      end
      ST_NORM_ACC: begin
        sum_nxt = sum_r + q16_sq(crd_rdata);
        if (idx_r == (DIM_W+1)'(DIMENSIONS)) begin
          state_nxt = ST_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_nxt.accepted         = acc_r;
          out_nxt.stasis           = stasis_r;
          out_nxt.suspend_pulse    = pulse_r;
          out_nxt.locked           = locked_r;
          out_nxt.divergence       = div_r;
          out_nxt.coord_norm       = signed'(sum_r);
          out_nxt.transition_count = trans_r;
          out_nxt.clamp_count      = clamp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      sum_r       <= '0;
      div_r       <= '0;
      trans_r     <= '0;
      clamp_r     <= '0;
      locked_r    <= 1'b1;
      stasis_r    <= 1'b0;
      acc_r       <= 1'b0;
      pulse_r     <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= DRIFT_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      div_r       <= div_nxt;
      trans_r     <= trans_nxt;
      clamp_r     <= clamp_nxt;
      locked_r    <= locked_nxt;
      stasis_r    <= stasis_nxt;
      acc_r       <= acc_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) limit_r <= signed'(cfg_data);
    end
    req_r     <= req_nxt;
    vel_r     <= vel_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/vdm_div.sv]
// Restoring divider: 64-bit numerator by 32-bit step, one quotient bit per cycle
module vdm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vdm_pkg::vdm_div_req_t req,
  output vdm_pkg::vdm_div_rsp_t rsp
);
  import vdm_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] trial;
  logic [63:0] qfull;
  logic signed [31:0] step_eff;
  logic [63:0] mag_num;

  always_comb begin
    step_eff = (req.step <= 0) ? Q16_ONE : req.step;
    mag_num  = req.diff[31] ? 64'(-(64'(signed'(req.diff)) <<< 16))
                            : (64'(signed'(req.diff)) <<< 16);
    trial    = {rem_r[31:0], num_r[63]} - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.diff[31];
      cnt_nxt  = 7'd0;
      num_nxt  = mag_num;
      den_nxt  = 32'(step_eff);
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift one numerator bit in, quotient bit shifts into num low end
      if (!trial[32]) begin
        rem_nxt = trial;
        num_nxt = {num_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], num_r[63]};
        num_nxt = {num_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign qfull    = neg_r ? (~num_r + 64'd1) : num_r;
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = signed'(qfull[31:0]);

endmodule

[rtl/vdm_vec_mem.sv]
// Coordinate and velocity memories, registered synchronous read, valid bits for reset
module vdm_vec_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [vdm_pkg::DIM_W-1:0] rd_addr,
  output logic signed [31:0]        crd_rdata,
  output logic signed [31:0]        vel_rdata,
  input  logic                      crd_we,
  input  logic                      vel_we,
  input  logic [vdm_pkg::DIM_W-1:0] wr_addr,
  input  logic signed [31:0]        crd_wdata,
  input  logic signed [31:0]        vel_wdata
);
  import vdm_pkg::*;

  logic signed [31:0] crd_mem [DIMENSIONS];
  logic signed [31:0] vel_mem [DIMENSIONS];
  logic [DIMENSIONS-1:0] crd_vld_r;
  logic [DIMENSIONS-1:0] vel_vld_r;
  logic signed [31:0] crd_q_r, vel_q_r;
  logic crd_v_r, vel_v_r;

  always_ff @(posedge clk) begin
    if (crd_we) crd_mem[wr_addr] <= crd_wdata;
    if (vel_we) vel_mem[wr_addr] <= vel_wdata;
    crd_q_r <= crd_mem[rd_addr];
    vel_q_r <= vel_mem[rd_addr];
  end

  // valid bits stand in for the all-zero reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crd_vld_r <= '0;
      vel_vld_r <= '0;
      crd_v_r   <= 1'b0;
      vel_v_r   <= 1'b0;
    end else begin
      if (crd_we) crd_vld_r[wr_addr] <= 1'b1;
      if (vel_we) vel_vld_r[wr_addr] <= 1'b1;
      crd_v_r <= crd_vld_r[rd_addr];
      vel_v_r <= vel_vld_r[rd_addr];
    end
  end

  assign crd_rdata = crd_v_r ? crd_q_r : '0;
  assign vel_rdata = vel_v_r ? vel_q_r : '0;

endmodule

[rtl/vdm_checker.sv]
// Port-level checker for the drift monitor, bound to the top level
module vdm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input vdm_pkg::vdm_out_t out_data
);
  import vdm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // accepted never together with stasis or a pulse
  a_acc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.stasis && !out_data.suspend_pulse)
    else $error("accepted with stasis");

  // a pulse always reports stasis, zero divergence, unlocked
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.suspend_pulse |->
      out_data.stasis && !out_data.locked && out_data.divergence == '0)
    else $error("stasis pulse inconsistent");

  // an accepted request blocks further requests right after it is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind velocity_drift_monitor vdm_checker u_vdm_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
